// ----- hw/rtl/sws_pkg.sv -----
// shared types and constants for the symbol weight sorter
`default_nettype none

package sws_pkg;

    localparam int ENTRIES_DEF     = 256;
    localparam int WEIGHT_BITS_DEF = 32;

    localparam int SYM_W    = 8;
    localparam int IN_WT_W  = 32;
    localparam int HELD_W   = 9;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } t_cell_ctl;

    // one result beat
    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic [IN_WT_W-1:0] weight;
        logic               popped;
        logic               last_entry;
        logic               dropped;
        logic [HELD_W-1:0]  held_count;
        logic               too_few;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/sws_cell.sv -----
// one compare-and-shift cell of the sorted table
`default_nettype none

module sws_cell #(
    parameter int WEIGHT_BITS = sws_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire sws_pkg::t_cell_ctl       i_ctl,
    input  wire logic [sws_pkg::SYM_W-1:0] i_new_symbol,
    input  wire logic [WEIGHT_BITS-1:0]   i_new_weight,
    input  wire logic [sws_pkg::SYM_W-1:0] i_prev_symbol,
    input  wire logic [WEIGHT_BITS-1:0]   i_prev_weight,
    input  wire logic                     i_prev_valid,
    input  wire logic                     i_prev_before,
    input  wire logic [sws_pkg::SYM_W-1:0] i_next_symbol,
    input  wire logic [WEIGHT_BITS-1:0]   i_next_weight,
    input  wire logic                     i_next_valid,
    output logic [sws_pkg::SYM_W-1:0]     o_symbol,
    output logic [WEIGHT_BITS-1:0]        o_weight,
    output logic                          o_valid,
    output logic                          o_before
);

    logic [sws_pkg::SYM_W-1:0] r_symbol, n_symbol;
    logic [WEIGHT_BITS-1:0]    r_weight, n_weight;
    logic                      r_valid, n_valid;
    logic                      w_before;

    // new entry sorts ahead of this one (empty cells always lose)
    assign w_before = !r_valid
                    || (i_new_weight > r_weight)
                    || ((i_new_weight == r_weight) && (i_new_symbol < r_symbol));

    always_comb begin
        n_symbol = r_symbol;
        n_weight = r_weight;
        n_valid  = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.pop) begin
            n_symbol = i_next_symbol;
            n_weight = i_next_weight;
            n_valid  = i_next_valid;
        end else if (i_ctl.insert) begin
            n_valid = r_valid | i_prev_valid;
            if (w_before) begin
                if (i_prev_before) begin
                    n_symbol = i_prev_symbol;
                    n_weight = i_prev_weight;
                end else begin
                    n_symbol = i_new_symbol;
                    n_weight = i_new_weight;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_symbol <= n_symbol;
        r_weight <= n_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_symbol = r_symbol;
    assign o_weight = r_weight;
    assign o_valid  = r_valid;
    assign o_before = w_before;

endmodule

`default_nettype wire

// ----- hw/rtl/sws_chain.sv -----
// row of sorter cells, heaviest entry at the head
`default_nettype none

module sws_chain #(
    parameter int ENTRIES     = sws_pkg::ENTRIES_DEF,
    parameter int WEIGHT_BITS = sws_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sws_pkg::t_cell_ctl        i_ctl,
    input  wire logic [sws_pkg::SYM_W-1:0] i_new_symbol,
    input  wire logic [WEIGHT_BITS-1:0]    i_new_weight,
    output logic [sws_pkg::SYM_W-1:0]      o_head_symbol,
    output logic [WEIGHT_BITS-1:0]         o_head_weight,
    output logic                           o_head_valid
);

    logic [sws_pkg::SYM_W-1:0] w_symbol [ENTRIES];
    logic [WEIGHT_BITS-1:0]    w_weight [ENTRIES];
    logic                      w_valid  [ENTRIES];
    logic                      w_before [ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic [sws_pkg::SYM_W-1:0] w_prev_symbol, w_next_symbol;
            logic [WEIGHT_BITS-1:0]    w_prev_weight, w_next_weight;
            logic                      w_prev_valid, w_prev_before, w_next_valid;

            if (gi == 0) begin : g_head
                // head takes the new entry whenever it sorts first
                assign w_prev_symbol = '0;
                assign w_prev_weight = '0;
                assign w_prev_valid  = 1'b1;
                assign w_prev_before = 1'b0;
            end else begin : g_body
                assign w_prev_symbol = w_symbol[gi-1];
                assign w_prev_weight = w_weight[gi-1];
                assign w_prev_valid  = w_valid[gi-1];
                assign w_prev_before = w_before[gi-1];
            end

            if (gi == ENTRIES - 1) begin : g_tail
                assign w_next_symbol = '0;
                assign w_next_weight = '0;
                assign w_next_valid  = 1'b0;
            end else begin : g_mid
                assign w_next_symbol = w_symbol[gi+1];
                assign w_next_weight = w_weight[gi+1];
                assign w_next_valid  = w_valid[gi+1];
            end

            sws_cell #(
                .WEIGHT_BITS(WEIGHT_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_new_symbol (i_new_symbol),
                .i_new_weight (i_new_weight),
                .i_prev_symbol(w_prev_symbol),
                .i_prev_weight(w_prev_weight),
                .i_prev_valid (w_prev_valid),
                .i_prev_before(w_prev_before),
                .i_next_symbol(w_next_symbol),
                .i_next_weight(w_next_weight),
                .i_next_valid (w_next_valid),
                .o_symbol     (w_symbol[gi]),
                .o_weight     (w_weight[gi]),
                .o_valid      (w_valid[gi]),
                .o_before     (w_before[gi])
            );
        end
    endgenerate

    assign o_head_symbol = w_symbol[0];
    assign o_head_weight = w_weight[0];
    assign o_head_valid  = w_valid[0];

    generate
        for (gi = 1; gi < ENTRIES; gi++) begin : g_chk
            // occupied cells form a prefix
            a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_valid[gi] |-> w_valid[gi-1])
                else $error("hole in occupied cells");

            // neighbors stay in order
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_valid[gi] |-> ((w_weight[gi-1] > w_weight[gi])
                    || ((w_weight[gi-1] == w_weight[gi])
                        && (w_symbol[gi-1] <= w_symbol[gi]))))
                else $error("table out of order");

            // insert position flags rise once along the row
            a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (i_ctl.insert && w_before[gi-1]) |-> w_before[gi])
                else $error("insert position not unique");
        end
    endgenerate

endmodule

`default_nettype wire

// ----- hw/rtl/sws_outq.sv -----
// two-slot result queue between the table and the output port
`default_nettype none

module sws_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sws_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output sws_pkg::t_result      o_data
);

    sws_pkg::t_result r_slot [2];
    logic             r_wr, n_wr;
    logic             r_rd, n_rd;
    logic [1:0]       r_cnt, n_cnt;
    logic             w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_slot[r_rd];
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = !r_wr;
        end
        if (w_pop) begin
            n_rd = !r_rd;
        end
        case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/symbol_weight_sorter.sv -----
// top level of the symbol weight sorter: sorted cell row plus result queue
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  ---------------------------------------------
//  command  in   i_valid / o_stall   i_operation, i_symbol, i_weight
//  result   out  o_valid / i_stall   o_out_symbol, o_out_weight, o_popped,
//                                    o_last_entry, o_dropped, o_held_count, o_too_few
//
//  one command beat per cycle while o_stall is low; every cell compares and shifts in the same cycle
//  the result of a beat enters the queue at the edge that takes it, shown once it reaches the queue head
//  a two-slot result queue sets o_stall; it rises only when both slots wait
//  no clearing pass: cell valid flags reset at once, ready right after reset
//  insert, pop and clear each act on every cell in parallel whatever the fill level
`default_nettype none

module symbol_weight_sorter #(
    parameter int ENTRIES     = sws_pkg::ENTRIES_DEF,
    parameter int WEIGHT_BITS = sws_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [sws_pkg::OP_W-1:0]    i_operation,
    input  wire logic [sws_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic [sws_pkg::IN_WT_W-1:0] i_weight,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sws_pkg::SYM_W-1:0]        o_out_symbol,
    output logic [sws_pkg::IN_WT_W-1:0]      o_out_weight,
    output logic                             o_popped,
    output logic                             o_last_entry,
    output logic                             o_dropped,
    output logic [sws_pkg::HELD_W-1:0]       o_held_count,
    output logic                             o_too_few
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    // entry count
    logic [CNT_W-1:0] r_count, n_count;

    logic                              w_fire;
    logic                              w_full;
    logic                              w_nonzero;
    logic [WEIGHT_BITS-1:0]            w_sat_weight;
    logic [sws_pkg::IN_WT_W-1:0]       w_head_weight_out;
    logic [sws_pkg::HELD_W-1:0]        w_held;
    sws_pkg::t_cell_ctl                w_ctl;
    sws_pkg::t_result                  w_result;
    sws_pkg::t_result                  w_q_data;
    logic                              w_q_full;
    logic [sws_pkg::SYM_W-1:0]         w_head_symbol;
    logic [WEIGHT_BITS-1:0]            w_head_weight;
    logic                              w_head_valid;

    assign w_fire    = i_valid && !w_q_full;
    assign w_full    = (r_count == CNT_W'(ENTRIES));
    assign w_nonzero = (i_weight != '0);
    assign o_stall   = w_q_full;

    // fit the incoming count into the table's weight width, saturating
    generate
        if (WEIGHT_BITS < sws_pkg::IN_WT_W) begin : g_sat_narrow
            assign w_sat_weight = (|i_weight[sws_pkg::IN_WT_W-1:WEIGHT_BITS])
                                ? '1 : i_weight[WEIGHT_BITS-1:0];
            assign w_head_weight_out = {{(sws_pkg::IN_WT_W-WEIGHT_BITS){1'b0}},
                                        w_head_weight};
        end else if (WEIGHT_BITS == sws_pkg::IN_WT_W) begin : g_sat_same
            assign w_sat_weight      = i_weight;
            assign w_head_weight_out = w_head_weight;
        end else begin : g_sat_wide
            assign w_sat_weight = {{(WEIGHT_BITS-sws_pkg::IN_WT_W){1'b0}}, i_weight};
            assign w_head_weight_out = w_head_weight[sws_pkg::IN_WT_W-1:0];
        end
    endgenerate

    // held count is reported in a fixed 9-bit field
    generate
        if (CNT_W >= sws_pkg::HELD_W) begin : g_held_cut
            assign w_held = n_count[sws_pkg::HELD_W-1:0];
        end else begin : g_held_ext
            assign w_held = {{(sws_pkg::HELD_W-CNT_W){1'b0}}, n_count};
        end
    endgenerate

    // decode the command and build its result
    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        w_result = '0;
        if (w_fire) begin
            case (sws_pkg::t_op'(i_operation))
                sws_pkg::OP_INSERT: begin
                    if (w_nonzero) begin
                        if (w_full) begin
                            w_result.dropped = 1'b1;
                        end else begin
                            w_ctl.insert = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                end
                sws_pkg::OP_POP: begin
                    if (w_head_valid) begin
                        w_ctl.pop         = 1'b1;
                        n_count           = r_count - CNT_W'(1);
                        w_result.symbol   = w_head_symbol;
                        w_result.weight   = w_head_weight_out;
                        w_result.popped   = 1'b1;
                        w_result.last_entry = (r_count == CNT_W'(1));
                    end
                end
                sws_pkg::OP_CLEAR: begin
                    w_ctl.clear = 1'b1;
                    n_count     = '0;
                end
                default: begin
                    // unused code: counts only
                end
            endcase
        end
        w_result.held_count = w_held;
        w_result.too_few    = (n_count < CNT_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    sws_chain #(
        .ENTRIES    (ENTRIES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_new_symbol (i_symbol),
        .i_new_weight (w_sat_weight),
        .o_head_symbol(w_head_symbol),
        .o_head_weight(w_head_weight),
        .o_head_valid (w_head_valid)
    );

    sws_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fire),
        .i_data (w_result),
        .o_full (w_q_full),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (w_q_data)
    );

    assign o_out_symbol = w_q_data.symbol;
    assign o_out_weight = w_q_data.weight;
    assign o_popped     = w_q_data.popped;
    assign o_last_entry = w_q_data.last_entry;
    assign o_dropped    = w_q_data.dropped;
    assign o_held_count = w_q_data.held_count;
    assign o_too_few    = w_q_data.too_few;

    // head cell occupied exactly when the count is nonzero
    a_count_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_head_valid)
        else $error("entry count disagrees with head cell");

endmodule

`default_nettype wire
